>>> rtl/core/eabs_pkg.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother package
// Shared types, codes and constants of the 3x3 mean filter core.
// ----------------------------------------------------------------------------
package eabs_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;
  localparam int MEAN_W  = 16;
  localparam int SUM_W   = 12;
  localparam int NUM_W   = 20;
  localparam int RECIP_W = 21;
  localparam int KIND_W  = 4;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = 2;
  localparam int JOBQ_CW    = 3;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] FRAME_RESET = 11'd257;

  // Result kinds an input can cause, in delivery order.
  localparam int KIND_CENTER   = 0;
  localparam int KIND_ROW_END  = 1;
  localparam int KIND_LAST_ROW = 2;
  localparam int KIND_CORNER   = 3;

  typedef enum logic [1:0] {
    ODD_1 = 2'd0,
    ODD_3 = 2'd1,
    ODD_9 = 2'd2
  } odd_t;

  // floor(2^21/d), 2^21-1 at d=1; one correction fixes the one-sided error.
  localparam logic [RECIP_W-1:0] RECIP_1 = 21'd2097151;
  localparam logic [RECIP_W-1:0] RECIP_3 = 21'd699050;
  localparam logic [RECIP_W-1:0] RECIP_9 = 21'd233016;

  typedef struct packed {
    logic [1:0] shift;
    odd_t       odd;
    logic [2:0] half;
  } div_sel_t;

  typedef struct packed {
    logic [COORD_W-1:0]          row;
    logic [COORD_W-1:0]          col;
    logic [KIND_W-1:0]           kinds;
    logic                        r_ge1;
    logic                        r_ge2;
    logic                        c_ge1;
    logic                        c_ge2;
    logic [8:0][PIX_W-1:0]       win;
  } job_t;

  // Divisor n is split into a power of two and an odd factor of 1, 3 or 9.
  function automatic div_sel_t div_select(input logic [3:0] n);
    div_sel_t d;
    d.shift = 2'd0;
    d.odd   = ODD_1;
    d.half  = 3'd0;
    case (n)
      4'd1: begin
        d.shift = 2'd0; d.odd = ODD_1; d.half = 3'd0;
      end
      4'd2: begin
        d.shift = 2'd1; d.odd = ODD_1; d.half = 3'd1;
      end
      4'd3: begin
        d.shift = 2'd0; d.odd = ODD_3; d.half = 3'd1;
      end
      4'd4: begin
        d.shift = 2'd2; d.odd = ODD_1; d.half = 3'd2;
      end
      4'd6: begin
        d.shift = 2'd1; d.odd = ODD_3; d.half = 3'd3;
      end
      4'd9: begin
        d.shift = 2'd0; d.odd = ODD_9; d.half = 3'd4;
      end
      default: begin
        d.shift = 2'd0; d.odd = ODD_1; d.half = 3'd0;
      end
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/eabs_front.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother front end
// Accepts samples, tracks the raster position, keeps the line store and the
// 3x3 window, and classifies each sample into the results it causes.
// ----------------------------------------------------------------------------
module eabs_front #(
  parameter int MAX_WIDTH = 1025
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [eabs_pkg::COORD_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [eabs_pkg::PIX_W-1:0]    in_height_sample,
  output logic                          job_valid,
  input  logic                          job_ready,
  output eabs_pkg::job_t                job
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [eabs_pkg::COORD_W-1:0] fw_r, fh_r;
  logic [eabs_pkg::COORD_W-1:0] w_last, h_last;
  logic [eabs_pkg::COORD_W-1:0] row_r, row_nxt, col_r, col_nxt;

  logic                         a_v_r;
  logic [eabs_pkg::PIX_W-1:0]   a_x_r;
  logic [eabs_pkg::COORD_W-1:0] a_row_r, a_col_r;
  logic                         a_lastc_r, a_lastr_r;

  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd_r, byp_d_r, line_word, wr_word;
  logic        byp_r;
  logic [AW-1:0] in_addr, a_addr;

  logic [8:0][eabs_pkg::PIX_W-1:0] win_r, win_nxt;
  logic [eabs_pkg::KIND_W-1:0] kinds;
  logic r_ge1, r_ge2, c_ge1, c_ge2;
  logic in_fire, a_adv;

  always_comb begin
    if (fw_r == '0) begin
      w_last = '0;
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_last = eabs_pkg::COORD_W'(MAX_WIDTH - 1);
    end else begin
      w_last = fw_r - 11'd1;
    end
    h_last = (fh_r == '0) ? '0 : fh_r - 11'd1;
  end

  assign r_ge1 = (a_row_r != '0);
  assign r_ge2 = (a_row_r > 11'd1);
  assign c_ge1 = (a_col_r != '0);
  assign c_ge2 = (a_col_r > 11'd1);

  always_comb begin
    kinds = '0;
    kinds[eabs_pkg::KIND_CENTER]   = r_ge1 & c_ge1;
    kinds[eabs_pkg::KIND_ROW_END]  = r_ge1 & a_lastc_r;
    kinds[eabs_pkg::KIND_LAST_ROW] = a_lastr_r & c_ge1;
    kinds[eabs_pkg::KIND_CORNER]   = a_lastr_r & a_lastc_r;
  end

  assign a_adv    = a_v_r && ((kinds == '0) || job_ready);
  assign in_ready = !a_v_r || a_adv;
  assign in_fire  = in_valid && in_ready;

  assign in_addr   = AW'(col_r);
  assign a_addr    = AW'(a_col_r);
  assign line_word = byp_r ? byp_d_r : rd_r;
  assign wr_word   = {line_word[7:0], a_x_r};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      win_nxt[a*3]     = win_r[a*3+1];
      win_nxt[a*3 + 1] = win_r[a*3+2];
    end
    win_nxt[2] = line_word[15:8];
    win_nxt[5] = line_word[7:0];
    win_nxt[8] = a_x_r;
  end

  always_comb begin
    if (col_r == w_last) begin
      col_nxt = '0;
      row_nxt = (row_r == h_last) ? '0 : row_r + 11'd1;
    end else begin
      col_nxt = col_r + 11'd1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= eabs_pkg::FRAME_RESET;
      fh_r  <= eabs_pkg::FRAME_RESET;
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == eabs_pkg::CFG_FRAME_WIDTH) begin
        fw_r <= cfg_wdata;
      end else begin
        fh_r <= cfg_wdata;
      end
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      byp_r <= 1'b0;
      win_r <= '0;
    end else begin
      if (in_fire) begin
        a_v_r <= 1'b1;
        byp_r <= a_adv && (a_addr == in_addr);
      end else if (a_adv) begin
        a_v_r <= 1'b0;
      end
      if (a_adv) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_x_r     <= in_height_sample;
      a_row_r   <= row_r;
      a_col_r   <= col_r;
      a_lastc_r <= (col_r == w_last);
      a_lastr_r <= (row_r == h_last);
      byp_d_r   <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      line_mem[a_addr] <= wr_word;
    end
    if (in_fire) begin
      rd_r <= line_mem[in_addr];
    end
  end

  assign job_valid = a_v_r && (kinds != '0);

  always_comb begin
    job.row   = a_row_r;
    job.col   = a_col_r;
    job.kinds = kinds;
    job.r_ge1 = r_ge1;
    job.r_ge2 = r_ge2;
    job.c_ge1 = c_ge1;
    job.c_ge2 = c_ge2;
    job.win   = win_nxt;
  end

endmodule

>>> rtl/core/eabs_jobq.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother job queue
// Short FIFO of classified samples between the front end and the back end.
// ----------------------------------------------------------------------------
module eabs_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  eabs_pkg::job_t push_job,
  output logic           head_valid,
  input  logic           pop,
  output eabs_pkg::job_t head_job
);

  eabs_pkg::job_t                slot_r [eabs_pkg::JOBQ_DEPTH];
  logic [eabs_pkg::JOBQ_AW-1:0] wp_r, rp_r;
  logic [eabs_pkg::JOBQ_CW-1:0] cnt_r;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != eabs_pkg::JOBQ_CW'(eabs_pkg::JOBQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/eabs_back.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother back end
// Expands each job into its results, sums the in-frame neighbors and divides
// by the neighbor count through a reciprocal multiply with one correction.
// ----------------------------------------------------------------------------
module eabs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  eabs_pkg::job_t                job,
  output logic                          job_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [eabs_pkg::COORD_W-1:0]  out_row,
  output logic [eabs_pkg::COORD_W-1:0]  out_col,
  output logic [eabs_pkg::MEAN_W-1:0]   out_mean_value,
  output logic                          out_run_last
);

  logic [eabs_pkg::KIND_W-1:0] done_r, cur, sel;
  logic                        last0, emit;
  logic [2:0]                  rmask, cmask;
  logic [1:0]                  rcnt, ccnt;
  logic [eabs_pkg::COORD_W-1:0] row0, col0;
  logic [eabs_pkg::SUM_W-1:0]  sum0;
  eabs_pkg::div_sel_t          dsel0;

  logic                         v1_r, last1_r;
  logic [eabs_pkg::COORD_W-1:0] row1_r, col1_r;
  logic [eabs_pkg::SUM_W-1:0]   sum1_r;
  eabs_pkg::div_sel_t           dsel1_r;

  logic [eabs_pkg::NUM_W-1:0]   num1, np1;
  logic [eabs_pkg::RECIP_W-1:0] recip1;
  logic [eabs_pkg::NUM_W+eabs_pkg::RECIP_W-1:0] prod1;

  logic                         v2_r, last2_r;
  logic [eabs_pkg::COORD_W-1:0] row2_r, col2_r;
  logic [eabs_pkg::NUM_W-1:0]   np2_r, qa2_r;
  eabs_pkg::odd_t               odd2_r;

  logic [eabs_pkg::NUM_W-1:0]   qd2, od2, rem2, q2;

  logic                         out_v_r, out_last_r;
  logic [eabs_pkg::COORD_W-1:0] out_row_r, out_col_r;
  logic [eabs_pkg::MEAN_W-1:0]  out_mean_r;

  logic out_take, s2_take, s1_take;

  assign out_take = !out_v_r || out_ready;
  assign s2_take  = !v2_r || out_take;
  assign s1_take  = !v1_r || s2_take;

  assign cur     = job.kinds & ~done_r;
  assign sel     = cur & (~cur + 4'd1);
  assign last0   = ((cur & ~sel) == '0);
  assign emit    = job_valid && s1_take;
  assign job_pop = emit && last0;

  always_comb begin
    rmask = {1'b1, 1'b1, job.r_ge2};
    cmask = {1'b1, 1'b1, job.c_ge2};
    row0  = job.row - 11'd1;
    col0  = job.col - 11'd1;
    if (sel[eabs_pkg::KIND_ROW_END]) begin
      cmask = 3'b100;
      col0  = job.col;
    end else if (sel[eabs_pkg::KIND_LAST_ROW]) begin
      rmask = {1'b1, job.r_ge1, 1'b0};
      row0  = job.row;
    end else if (sel[eabs_pkg::KIND_CORNER]) begin
      rmask = {1'b1, job.r_ge1, 1'b0};
      cmask = {1'b1, job.c_ge1, 1'b0};
      row0  = job.row;
      col0  = job.col;
    end
  end

  always_comb begin
    sum0 = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (rmask[a] && cmask[b]) begin
          sum0 = sum0 + eabs_pkg::SUM_W'(job.win[a*3+b]);
        end
      end
    end
    rcnt  = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
    ccnt  = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
    dsel0 = eabs_pkg::div_select(4'(rcnt) * 4'(ccnt));
  end

  always_comb begin
    num1 = {sum1_r, 8'd0} + eabs_pkg::NUM_W'(dsel1_r.half);
    np1  = num1 >> dsel1_r.shift;
    case (dsel1_r.odd)
      eabs_pkg::ODD_3: recip1 = eabs_pkg::RECIP_3;
      eabs_pkg::ODD_9: recip1 = eabs_pkg::RECIP_9;
      default:         recip1 = eabs_pkg::RECIP_1;
    endcase
    prod1 = (eabs_pkg::NUM_W+eabs_pkg::RECIP_W)'(np1) *
            (eabs_pkg::NUM_W+eabs_pkg::RECIP_W)'(recip1);
  end

  always_comb begin
    case (odd2_r)
      eabs_pkg::ODD_3: begin
        qd2 = (qa2_r << 1) + qa2_r;
        od2 = 20'd3;
      end
      eabs_pkg::ODD_9: begin
        qd2 = (qa2_r << 3) + qa2_r;
        od2 = 20'd9;
      end
      default: begin
        qd2 = qa2_r;
        od2 = 20'd1;
      end
    endcase
    rem2 = np2_r - qd2;
    q2   = qa2_r + ((rem2 >= od2) ? 20'd1 : 20'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (emit) begin
        done_r <= last0 ? '0 : (done_r | sel);
      end
      if (s1_take) begin
        v1_r <= emit;
      end
      if (s2_take) begin
        v2_r <= v1_r;
      end
      if (out_take) begin
        out_v_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      row1_r  <= row0;
      col1_r  <= col0;
      last1_r <= last0;
      sum1_r  <= sum0;
      dsel1_r <= dsel0;
    end
    if (s2_take) begin
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      last2_r <= last1_r;
      np2_r   <= np1;
      qa2_r   <= prod1[eabs_pkg::NUM_W+eabs_pkg::RECIP_W-1:eabs_pkg::RECIP_W];
      odd2_r  <= dsel1_r.odd;
    end
    if (out_take) begin
      out_row_r  <= row2_r;
      out_col_r  <= col2_r;
      out_last_r <= last2_r;
      out_mean_r <= q2[eabs_pkg::MEAN_W-1:0];
    end
  end

  assign out_valid      = out_v_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_mean_value = out_mean_r;
  assign out_run_last   = out_last_r;

endmodule

>>> rtl/core/edge_aware_box_smoother_core.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother core
// 3x3 mean filter over an 8-bit heightmap stream with in-frame edge handling.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel in raster order, one per transfer. Each
// sample yields zero to four smoothed pixels on the out_ channel, each with
// its row, column, Q8.8 mean and a flag on the last pixel of that sample.
// Frame width and height are set through the cfg_ write port; the user must
// write them only while the core is idle, as the core does not enforce it.
// Any write restarts the frame at row 0, column 0. The core takes one sample
// per clock while the job queue has room; on the last row a sample yields up
// to four results and the output channel, at one result per clock while the
// receiver is ready, sets the pace. The line store has one read port and one
// write port, each used once per sample, so it keeps up with one sample per
// clock. Reset clears the position counters, the window and all pipeline and
// queue valid bits; the line store needs no clearing. When the receiver
// stalls, the output stages fill, then the job queue, then the input stops
// taking samples; no result is dropped or repeated.
// ----------------------------------------------------------------------------
module edge_aware_box_smoother_core #(
  parameter int MAX_WIDTH = 1025
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [eabs_pkg::COORD_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [eabs_pkg::PIX_W-1:0]    in_height_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [eabs_pkg::COORD_W-1:0]  out_row,
  output logic [eabs_pkg::COORD_W-1:0]  out_col,
  output logic [eabs_pkg::MEAN_W-1:0]   out_mean_value,
  output logic                          out_run_last
);

  logic           fe_job_valid, fe_job_ready;
  eabs_pkg::job_t fe_job;
  logic           q_head_valid, q_pop;
  eabs_pkg::job_t q_head;

  eabs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_height_sample (in_height_sample),
    .job_valid        (fe_job_valid),
    .job_ready        (fe_job_ready),
    .job              (fe_job)
  );

  eabs_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_job_valid),
    .push_ready (fe_job_ready),
    .push_job   (fe_job),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .head_job   (q_head)
  );

  eabs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_head_valid),
    .job            (q_head),
    .job_pop        (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_mean_value (out_mean_value),
    .out_run_last   (out_run_last)
  );

endmodule

>>> rtl/core/eabs_checker.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother port checker
// Watches the core's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module eabs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [eabs_pkg::COORD_W-1:0]  out_row,
  input logic [eabs_pkg::COORD_W-1:0]  out_col,
  input logic [eabs_pkg::MEAN_W-1:0]   out_mean_value,
  input logic                          out_run_last
);

  // After reset no result is pending.
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // After reset the input side is free to take a sample.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_mean_value) && $stable(out_run_last))
    else $error("stalled result changed");

  // A mean of 8-bit samples never exceeds 255.0 in Q8.8.
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mean_value <= 16'd65280)
    else $error("mean out of range");

endmodule

bind edge_aware_box_smoother_core eabs_checker u_eabs_checker (.*);

>>> sim/edge_aware_box_smoother_core_tb.sv
// ----------------------------------------------------------------------------
// Edge-aware box smoother core testbench
// Streams heightmap samples through the core under several frame sizes and
// checks every smoothed pixel against a cycle-free model of the 3x3 mean
// filter. A short table of directed steps comes first, then a few samples of
// a tall narrow frame, then random frames; sender gaps and receiver stalls
// are random throughout.
// ----------------------------------------------------------------------------
module edge_aware_box_smoother_core_tb;

  localparam int COORD_W      = eabs_pkg::COORD_W;
  localparam int PIX_W        = eabs_pkg::PIX_W;
  localparam int MEAN_W       = eabs_pkg::MEAN_W;
  localparam int LINE_MAX     = 1025;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 450;
  localparam int LIMIT_CYCLES = 600000;
  localparam int NO_TYPED     = -1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_SET_WIDTH,
    OP_SET_HEIGHT
  } step_op_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_BURSTY
  } rx_mode_t;

  typedef struct {
    step_op_t           op;
    logic [COORD_W-1:0] value;
    int                 typed_cnt;
    logic [MEAN_W-1:0]  typed_mean;
  } step_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [MEAN_W-1:0]  mean;
    logic               last;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = 1'b0;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   in_height_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [MEAN_W-1:0]  out_mean_value;
  logic               out_run_last;

  logic [COORD_W-1:0] frame_w = eabs_pkg::FRAME_RESET;
  logic [COORD_W-1:0] frame_h = eabs_pkg::FRAME_RESET;
  logic [PIX_W-1:0]   line_mem [2*LINE_MAX];
  logic [PIX_W-1:0]   win_regs [9];
  int unsigned        row_ctr = 0;
  int unsigned        col_ctr = 0;
  pixel_t             new_pixel [4];
  pixel_t             pending_pixels [$];

  int errors = 0;
  int samples_sent = 0;
  int pixels_checked = 0;
  int settings_used = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;

  step_t plan [0:25] = '{
    '{OP_SAMPLE,     11'd255,  0,        16'd0},
    '{OP_SAMPLE,     11'd0,    0,        16'd0},
    '{OP_SET_WIDTH,  11'd2,    NO_TYPED, 16'd0},
    '{OP_SET_HEIGHT, 11'd2,    NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd255,  0,        16'd65280},
    '{OP_SAMPLE,     11'd255,  0,        16'd65280},
    '{OP_SAMPLE,     11'd255,  0,        16'd65280},
    '{OP_SAMPLE,     11'd255,  4,        16'd65280},
    '{OP_SAMPLE,     11'd0,    0,        16'd0},
    '{OP_SAMPLE,     11'd0,    0,        16'd0},
    '{OP_SAMPLE,     11'd0,    0,        16'd0},
    '{OP_SAMPLE,     11'd0,    4,        16'd0},
    '{OP_SET_WIDTH,  11'd0,    NO_TYPED, 16'd0},
    '{OP_SET_HEIGHT, 11'd0,    NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd200,  1,        16'd51200},
    '{OP_SAMPLE,     11'd255,  1,        16'd65280},
    '{OP_SET_WIDTH,  11'd2047, NO_TYPED, 16'd0},
    '{OP_SET_HEIGHT, 11'd1,    NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd17,   NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd128,  NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd255,  NO_TYPED, 16'd0},
    '{OP_SET_HEIGHT, 11'd3,    NO_TYPED, 16'd0},
    '{OP_SET_WIDTH,  11'd1,    NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd10,   NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd20,   NO_TYPED, 16'd0},
    '{OP_SAMPLE,     11'd30,   NO_TYPED, 16'd0}
  };

  edge_aware_box_smoother_core #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_height_sample(in_height_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_row(out_row),
    .out_col(out_col),
    .out_mean_value(out_mean_value),
    .out_run_last(out_run_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(frame_w);
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (frame_h == 0) ? 1 : 32'(frame_h);
  endfunction

  function automatic logic [MEAN_W-1:0] box_mean(input logic [2:0] rmask,
                                                 input logic [2:0] cmask);
    int unsigned sum;
    int unsigned n;
    sum = 0;
    n = 0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if (rmask[a] && cmask[b]) begin
          sum += 32'(win_regs[a*3 + b]);
          n++;
        end
      end
    end
    if (n == 0) return '0;
    return MEAN_W'(((sum << 8) + (n >> 1)) / n);
  endfunction

  // Advances the filter by one sample and leaves the pixels it yields in
  // new_pixel, in delivery order; returns how many there are.
  function automatic int smooth_sample(input logic [PIX_W-1:0] x);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    logic [2:0] rfull;
    logic [2:0] rlast;
    logic [2:0] cfull;
    logic [2:0] cend;
    int k;
    w = eff_width();
    h = eff_height();
    r = (row_ctr >= h) ? h - 1 : row_ctr;
    c = (col_ctr >= w) ? w - 1 : col_ctr;
    k = 0;
    up1 = line_mem[c];
    up2 = line_mem[LINE_MAX + c];
    line_mem[LINE_MAX + c] = up1;
    line_mem[c] = x;
    for (int i = 0; i < 9; i += 3) begin
      win_regs[i] = win_regs[i+1];
      win_regs[i+1] = win_regs[i+2];
    end
    win_regs[2] = up2;
    win_regs[5] = up1;
    win_regs[8] = x;
    rfull = {2'b11, r >= 2};
    rlast = {1'b1, r >= 1, 1'b0};
    cfull = {2'b11, c >= 2};
    cend  = {1'b1, c >= 1, 1'b0};
    if (r >= 1 && c >= 1) begin
      new_pixel[k] = '{COORD_W'(r - 1), COORD_W'(c - 1), box_mean(rfull, cfull), 1'b0};
      k++;
    end
    if (r >= 1 && c == w - 1) begin
      new_pixel[k] = '{COORD_W'(r - 1), COORD_W'(c), box_mean(rfull, 3'b100), 1'b0};
      k++;
    end
    if (r == h - 1 && c >= 1) begin
      new_pixel[k] = '{COORD_W'(r), COORD_W'(c - 1), box_mean(rlast, cfull), 1'b0};
      k++;
    end
    if (r == h - 1 && c == w - 1) begin
      new_pixel[k] = '{COORD_W'(r), COORD_W'(c), box_mean(rlast, cend), 1'b0};
      k++;
    end
    if (k > 0) new_pixel[k-1].last = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_ctr = r;
    col_ctr = c;
    return k;
  endfunction

  function automatic logic [COORD_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return COORD_W'($urandom_range(0, 1));
    if (roll < 90) return COORD_W'($urandom_range(2, 7));
    return COORD_W'($urandom_range(8, 12));
  endfunction

  task automatic write_reg(input logic idx, input logic [COORD_W-1:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == eabs_pkg::CFG_FRAME_WIDTH) begin
      frame_w = val;
    end else begin
      frame_h = val;
    end
    row_ctr = 0;
    col_ctr = 0;
    settings_used++;
  endtask

  task automatic send_sample(input logic [PIX_W-1:0] x, input int typed_cnt,
                             input logic [MEAN_W-1:0] typed_mean);
    int cnt;
    int k;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid = 1'b1;
    in_height_sample = x;
    do @(posedge clk); while (!in_ready);
    cnt = smooth_sample(x);
    if (typed_cnt != NO_TYPED && cnt != typed_cnt) begin
      $error("pixel count of sample %0d: table gives %0d, filter gives %0d",
             samples_sent, typed_cnt, cnt);
      errors++;
    end
    for (k = 0; k < cnt; k++) begin
      if (typed_cnt != NO_TYPED) new_pixel[k].mean = typed_mean;
      pending_pixels.insert(pending_pixels.size(), new_pixel[k]);
    end
    samples_sent++;
  endtask

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (hold_left != 0) begin
          out_ready <= 1'b0;
          hold_left <= hold_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) hold_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel (%0d,%0d) transferred with none expected", out_row, out_col);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, actual %0d", want.row, out_row);
          errors++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, actual %0d", want.col, out_col);
          errors++;
        end
        if (out_mean_value !== want.mean) begin
          $error("out_mean_value: expected %0d, actual %0d", want.mean, out_mean_value);
          errors++;
        end
        if (out_run_last !== want.last) begin
          $error("out_run_last: expected %0d, actual %0d", want.last, out_run_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int target;
    int area;
    int n;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win_regs[i]) win_regs[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      case (plan[i].op)
        OP_SAMPLE: begin
          send_sample(plan[i].value[PIX_W-1:0], plan[i].typed_cnt, plan[i].typed_mean);
        end
        OP_SET_WIDTH: begin
          write_reg(eabs_pkg::CFG_FRAME_WIDTH, plan[i].value);
        end
        default: begin
          write_reg(eabs_pkg::CFG_FRAME_HEIGHT, plan[i].value);
        end
      endcase
    end

    write_reg(eabs_pkg::CFG_FRAME_WIDTH, 11'd2);
    write_reg(eabs_pkg::CFG_FRAME_HEIGHT, 11'd1025);
    repeat (9) send_sample(PIX_W'($urandom_range(0, 255)), NO_TYPED, '0);

    target = samples_sent + RANDOM_ITEMS;
    while (samples_sent < target) begin
      write_reg(eabs_pkg::CFG_FRAME_WIDTH, pick_dim());
      write_reg(eabs_pkg::CFG_FRAME_HEIGHT, pick_dim());
      area = eff_width() * eff_height();
      n = area * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, area);
      if (n > target - samples_sent) n = target - samples_sent;
      repeat (n) send_sample(PIX_W'($urandom_range(0, 255)), NO_TYPED, '0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d samples streamed under %0d register writes,", samples_sent,
             settings_used);
    $display("summary: %0d smoothed pixels compared, %0d errors", pixels_checked, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
